// ----- design/ntbo_pkg.sv -----
// ----------------------------------------------------------------------------
// ntbo_pkg
// Shared widths and beat/stage types for the two-word by one-word divider.
// ----------------------------------------------------------------------------
package ntbo_pkg;

   localparam int WORD_BITS  = 32;
   localparam int HALF_BITS  = WORD_BITS / 2;
   localparam int DWORD_BITS = 2 * WORD_BITS;
   localparam int STEP_BITS  = 4;
   localparam int DIV_STAGES = HALF_BITS / STEP_BITS;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [HALF_BITS-1:0] half_type;
   typedef logic [HALF_BITS:0]   rhat_type;

   typedef struct packed {
      logic [DWORD_BITS-1:0] dividend;
      word_type              divisor;
   } req_type;

   typedef struct packed {
      word_type quotient;
      word_type remainder;
      logic     invalid;
   } rsp_type;

   typedef struct packed {
      half_type q_hi;
      half_type un_low;
      logic     invalid;
   } side_type;

   typedef struct packed {
      logic     valid;
      word_type u;
      half_type nxt;
      word_type v;
      side_type side;
   } digit_in_type;

   typedef struct packed {
      logic     valid;
      half_type qhat;
      rhat_type rhat;
      half_type nxt;
      word_type v;
      side_type side;
   } est_type;

   typedef struct packed {
      logic     valid;
      half_type q;
      word_type part;
      word_type v;
      side_type side;
   } part_type;

endpackage

// ----- design/ntbo_digit_div.sv -----
// ----------------------------------------------------------------------------
// ntbo_digit_div
// Pipelined half-word digit estimate: u / vn1, STEP_BITS quotient bits per
// stage, clamped to the largest digit when the top half of u equals vn1.
// ----------------------------------------------------------------------------
module ntbo_digit_div (
   input  logic                  clock,
   input  logic                  reset,
   input  ntbo_pkg::digit_in_type d_in,
   output ntbo_pkg::est_type     est_out
);
   import ntbo_pkg::*;

   typedef struct packed {
      logic     valid;
      logic     clamp;
      half_type rem;
      half_type quo;
      half_type low;
      rhat_type rhat_clamp;
      half_type nxt;
      word_type v;
      side_type side;
   } div_stage_type;

   div_stage_type entry;
   div_stage_type div_in [DIV_STAGES];
   div_stage_type div_ff [DIV_STAGES];

   function automatic div_stage_type div_step(div_stage_type cur);
      logic [HALF_BITS:0] trial;
      logic [HALF_BITS:0] dvs;
      div_stage_type      res;
      res = cur;
      dvs = {1'b0, cur.v[WORD_BITS-1:HALF_BITS]};
      for (int i = 0; i < STEP_BITS; i++) begin
         trial   = {res.rem, res.low[HALF_BITS-1]};
         res.low = {res.low[HALF_BITS-2:0], 1'b0};
         if (trial >= dvs) begin
            res.rem = HALF_BITS'(trial - dvs);
            res.quo = {res.quo[HALF_BITS-2:0], 1'b1};
         end else begin
            res.rem = trial[HALF_BITS-1:0];
            res.quo = {res.quo[HALF_BITS-2:0], 1'b0};
         end
      end
      return res;
   endfunction

   always_comb begin
      entry.valid      = d_in.valid;
      entry.clamp      = (d_in.u[WORD_BITS-1:HALF_BITS] == d_in.v[WORD_BITS-1:HALF_BITS]);
      entry.rem        = d_in.u[WORD_BITS-1:HALF_BITS];
      entry.quo        = '0;
      entry.low        = d_in.u[HALF_BITS-1:0];
      entry.rhat_clamp = {1'b0, d_in.u[HALF_BITS-1:0]} + {1'b0, d_in.v[WORD_BITS-1:HALF_BITS]};
      entry.nxt        = d_in.nxt;
      entry.v          = d_in.v;
      entry.side       = d_in.side;
      div_in[0] = div_step(entry);
      for (int s = 1; s < DIV_STAGES; s++) begin
         div_in[s] = div_step(div_ff[s-1]);
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (reset) begin
            div_ff[s] <= '0;
         end else begin
            div_ff[s] <= div_in[s];
         end
      end
   end

   always_comb begin
      est_out.valid = div_ff[DIV_STAGES-1].valid;
      est_out.qhat  = div_ff[DIV_STAGES-1].clamp ? '1 : div_ff[DIV_STAGES-1].quo;
      est_out.rhat  = div_ff[DIV_STAGES-1].clamp ? div_ff[DIV_STAGES-1].rhat_clamp
                                                 : {1'b0, div_ff[DIV_STAGES-1].rem};
      est_out.nxt   = div_ff[DIV_STAGES-1].nxt;
      est_out.v     = div_ff[DIV_STAGES-1].v;
      est_out.side  = div_ff[DIV_STAGES-1].side;
   end

endmodule

// ----- design/ntbo_digit_fix.sv -----
// ----------------------------------------------------------------------------
// ntbo_digit_fix
// Digit correction: qhat * vn0 product, two low-half product tests, then the
// partial remainder rhat * b + nxt - product.
// ----------------------------------------------------------------------------
module ntbo_digit_fix (
   input  logic               clock,
   input  logic               reset,
   input  ntbo_pkg::est_type  est_in,
   output ntbo_pkg::part_type part_out
);
   import ntbo_pkg::*;

   typedef struct packed {
      logic     valid;
      half_type q;
      rhat_type rhat;
      word_type p;
      half_type nxt;
      word_type v;
      side_type side;
   } fix_stage_type;

   fix_stage_type mul_in, mul_ff;
   fix_stage_type cor1_in, cor1_ff;
   fix_stage_type cor2_in, cor2_ff;
   part_type      out_in, out_ff;
   logic [WORD_BITS:0] part_full;

   function automatic fix_stage_type correct(fix_stage_type cur);
      fix_stage_type res;
      res = cur;
      if (!cur.rhat[HALF_BITS] && (cur.p > {cur.rhat[HALF_BITS-1:0], cur.nxt})) begin
         res.q    = cur.q - half_type'(1);
         res.rhat = cur.rhat + {1'b0, cur.v[WORD_BITS-1:HALF_BITS]};
         res.p    = cur.p - WORD_BITS'(cur.v[HALF_BITS-1:0]);
      end
      return res;
   endfunction

   always_comb begin
      mul_in.valid = est_in.valid;
      mul_in.q     = est_in.qhat;
      mul_in.rhat  = est_in.rhat;
      mul_in.p     = WORD_BITS'(est_in.qhat) * WORD_BITS'(est_in.v[HALF_BITS-1:0]);
      mul_in.nxt   = est_in.nxt;
      mul_in.v     = est_in.v;
      mul_in.side  = est_in.side;
      cor1_in      = correct(mul_ff);
      cor2_in      = correct(cor1_ff);
      part_full    = {cor2_ff.rhat, cor2_ff.nxt} - {1'b0, cor2_ff.p};
      out_in.valid = cor2_ff.valid;
      out_in.q     = cor2_ff.q;
      out_in.part  = part_full[WORD_BITS-1:0];
      out_in.v     = cor2_ff.v;
      out_in.side  = cor2_ff.side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= '0;
         cor1_ff <= '0;
         cor2_ff <= '0;
         out_ff  <= '0;
      end else begin
         mul_ff  <= mul_in;
         cor1_ff <= cor1_in;
         cor2_ff <= cor2_in;
         out_ff  <= out_in;
      end
   end

   assign part_out = out_ff;

endmodule

// ----- design/normalized_two_by_one_divider.sv -----
// ----------------------------------------------------------------------------
// normalized_two_by_one_divider
// Two-word by one-word unsigned divider, two half-word quotient digits.
// ----------------------------------------------------------------------------
// Fully pipelined: one beat accepted every cycle while busy is low. The
// result beat and rsp_strobe pass through the input register, 4 divide +
// 4 correction stages per quotient digit and the output register.
// busy is high only during and right after reset. Results cannot
// be held off; every result appears for one cycle. A divisor without its top
// bit set, or a dividend high word not below the divisor, gives invalid with
// zero quotient and remainder.
// ----------------------------------------------------------------------------
module normalized_two_by_one_divider (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ntbo_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output ntbo_pkg::rsp_type rsp_payload
);
   import ntbo_pkg::*;

   logic         busy_in, busy_ff;
   logic         in_valid_in, in_valid_ff;
   req_type      req_ff;
   logic         bad;
   digit_in_type d1_in, d2_in;
   est_type      est1, est2;
   part_type     part1, part2;
   logic         rsp_strobe_in, rsp_strobe_ff;
   rsp_type      rsp_in, rsp_ff;

   assign busy_in     = 1'b0;
   assign in_valid_in = start && !busy_ff;

   always_comb begin
      bad = !req_ff.divisor[WORD_BITS-1]
            || (req_ff.dividend[DWORD_BITS-1:WORD_BITS] >= req_ff.divisor);

      d1_in.valid       = in_valid_ff;
      d1_in.u           = req_ff.dividend[DWORD_BITS-1:WORD_BITS];
      d1_in.nxt         = req_ff.dividend[WORD_BITS-1:HALF_BITS];
      d1_in.v           = req_ff.divisor;
      d1_in.side.q_hi   = '0;
      d1_in.side.un_low = req_ff.dividend[HALF_BITS-1:0];
      d1_in.side.invalid = bad;

      d2_in.valid       = part1.valid;
      d2_in.u           = part1.part;
      d2_in.nxt         = part1.side.un_low;
      d2_in.v           = part1.v;
      d2_in.side.q_hi   = part1.q;
      d2_in.side.un_low = '0;
      d2_in.side.invalid = part1.side.invalid;

      rsp_strobe_in = part2.valid;
      rsp_in.invalid = part2.side.invalid;
      if (part2.side.invalid) begin
         rsp_in.quotient  = '0;
         rsp_in.remainder = '0;
      end else begin
         rsp_in.quotient  = {part2.side.q_hi, part2.q};
         rsp_in.remainder = part2.part;
      end
   end

   ntbo_digit_div u_div_hi (.clock(clock), .reset(reset), .d_in(d1_in), .est_out(est1));
   ntbo_digit_fix u_fix_hi (.clock(clock), .reset(reset), .est_in(est1), .part_out(part1));
   ntbo_digit_div u_div_lo (.clock(clock), .reset(reset), .d_in(d2_in), .est_out(est2));
   ntbo_digit_fix u_fix_lo (.clock(clock), .reset(reset), .est_in(est2), .part_out(part2));

   always_ff @(posedge clock) begin
      req_ff <= req_payload;
      rsp_ff <= rsp_in;
      if (reset) begin
         busy_ff       <= 1'b1;
         in_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         in_valid_ff   <= in_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign busy        = busy_ff;
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule
